>>> design/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the bitmap set, test and find-first block.
// ----------------------------------------------------------------------------
package bsf_pkg;

	localparam int SIZE_W = 11;
	localparam int IDX_W  = 10;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_TEST   = 2'd1,
		CMD_INVERT = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_MODIFY,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

>>> design/bsf_mem.sv
// ----------------------------------------------------------------------------
// bsf_mem
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsf_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                                     clk,
	input  bsf_pkg::mem_ctl_t                        ctl,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/bsf_div.sv
// ----------------------------------------------------------------------------
// bsf_div
// Splits a bit index into word index and bit offset: reciprocal estimate
// registered at load, then one compare and subtract correction.
// ----------------------------------------------------------------------------
module bsf_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [bsf_pkg::IDX_W-1:0]     bit_index,
	output logic [bsf_pkg::IDX_W-1:0]     word_index,
	output logic [$clog2(WORD_BITS)-1:0]  bit_offset
);

	localparam int IW    = bsf_pkg::IDX_W;
	localparam int OW    = $clog2(WORD_BITS);
	localparam int RECIP = 65536 / WORD_BITS;
	localparam int MW    = IW + 17;
	localparam int BKW   = IW + 8;
	localparam int RW    = IW + 1;

	logic [IW-1:0]  idx_q;
	logic [IW-1:0]  quo_q;
	logic [MW-1:0]  prod;
	logic [BKW-1:0] back;
	logic [RW-1:0]  rem;
	logic [RW-1:0]  rem_fix;
	logic           fix;

	assign prod = MW'(bit_index) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= bit_index;
			quo_q <= prod[IW+15:16];
		end
	end

	assign back    = BKW'(quo_q) * BKW'(WORD_BITS);
	assign rem     = {1'b0, idx_q} - back[RW-1:0];
	assign fix     = rem >= RW'(WORD_BITS);
	assign rem_fix = fix ? rem - RW'(WORD_BITS) : rem;

	assign word_index = fix ? quo_q + IW'(1) : quo_q;
	assign bit_offset = rem_fix[OW-1:0];

endmodule

>>> design/bitmap_set_test_find_first.sv
// ----------------------------------------------------------------------------
// bitmap_set_test_find_first
// Bitmap with running set-bit count: write, test, invert and find-first.
// ----------------------------------------------------------------------------
// write and test: one word read-modify-write through the split and modify states
// invert and find: one word per cycle through the single read port; find stops at
//   the first matching word
// busy stays high after reset and after every size write while the word store is
//   swept to zero
// the done strobe lasts one cycle and cannot be stalled; the next start may coincide
module bitmap_set_test_find_first #(
	parameter int MAX_BITS  = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsf_pkg::SIZE_W-1:0]     size_in_use,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     command,
	input  logic [bsf_pkg::IDX_W-1:0]      bit_index,
	input  logic                           bit_value,
	output logic                           done,
	output logic                           old_bit,
	output logic [bsf_pkg::SIZE_W-1:0]     set_count,
	output logic                           any_set,
	output logic                           all_set,
	output logic [bsf_pkg::IDX_W-1:0]      found_position,
	output logic                           found
);

	localparam int SW         = bsf_pkg::SIZE_W;
	localparam int IW         = bsf_pkg::IDX_W;
	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
	localparam int OW         = $clog2(WORD_BITS);
	localparam int BW         = SW + 1;
	localparam int SIZE_MAX   = (1 << SW) - 1;
	localparam logic [SW-1:0] SIZE_CAP  = SW'(MAX_BITS < SIZE_MAX ? MAX_BITS : SIZE_MAX);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
	localparam logic [BW-1:0] WORD_STEP = BW'(WORD_BITS);

	bsf_pkg::state_t   state_q, state_d;
	bsf_pkg::cmd_t     cmd_q;
	bsf_pkg::mem_ctl_t mem_ctl;

	logic [AW-1:0]        clr_addr_q;
	logic [SW-1:0]        size_q;
	logic [SW-1:0]        count_q;
	logic [SW-1:0]        count_next;
	logic [IW-1:0]        idx_q;
	logic                 val_q;
	logic [AW-1:0]        rd_addr_q;
	logic [BW-1:0]        base_q;
	logic                 valid_s1;
	logic [AW-1:0]        addr_s1;
	logic [BW-1:0]        base_s1;
	logic [OW-1:0]        off_s1;
	logic                 done_q;
	logic                 old_bit_q;
	logic [SW-1:0]        set_count_q;
	logic                 any_set_q;
	logic                 all_set_q;
	logic [IW-1:0]        found_pos_q;
	logic                 found_q;

	logic                 cfg_wr;
	logic                 accept;
	logic                 issue;
	logic                 in_range;
	logic                 cur_bit;
	logic                 find_hit;
	logic                 walk_end;
	logic                 finish;
	logic                 res_old;
	logic [IW-1:0]        div_word;
	logic [OW-1:0]        div_off;
	logic [IW+AW-1:0]     div_word_ext;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] set_word;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] low;
	logic [BW-1:0]        lim;
	logic [OW-1:0]        ffs;
	logic [BW-1:0]        find_pos;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = state_q != bsf_pkg::ST_IDLE;
	assign accept    = start & ~busy;

	bsf_div #(
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk       (clk),
		.load      (accept),
		.bit_index (bit_index),
		.word_index(div_word),
		.bit_offset(div_off)
	);

	assign div_word_ext = {{AW{1'b0}}, div_word};

	bsf_mem #(
		.DEPTH(WORD_COUNT),
		.WIDTH(WORD_BITS)
	) u_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// word datapath
	assign in_range = {1'b0, idx_q} < size_q;
	assign cur_bit  = rdata[off_s1];
	assign issue    = base_q < {1'b0, size_q};
	assign lim      = {1'b0, size_q} - base_s1;

	always_comb begin
		set_word         = rdata;
		set_word[off_s1] = val_q;
	end

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = BW'(b) < lim;
		end
	end

	assign cand = (val_q ? rdata : ~rdata) & mask;
	assign low  = cand & (~cand + WORD_BITS'(1));

	always_comb begin
		ffs = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			for (int k = 0; k < OW; k++) begin
				if (((b >> k) & 1) != 0) begin
					ffs[k] = ffs[k] | low[b];
				end
			end
		end
	end

	assign find_pos = base_s1 + BW'(ffs);
	assign find_hit = (cmd_q == bsf_pkg::CMD_FIND) && valid_s1 && (cand != '0);
	assign walk_end = find_hit || !issue;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsf_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = bsf_pkg::ST_IDLE;
				end
			end
			bsf_pkg::ST_IDLE: begin
				if (start) begin
					if (command == bsf_pkg::CMD_WRITE || command == bsf_pkg::CMD_TEST) begin
						state_d = bsf_pkg::ST_SPLIT;
					end else begin
						state_d = bsf_pkg::ST_WALK;
					end
				end
			end
			bsf_pkg::ST_SPLIT: begin
				state_d = bsf_pkg::ST_MODIFY;
			end
			bsf_pkg::ST_MODIFY: begin
				state_d = bsf_pkg::ST_IDLE;
			end
			bsf_pkg::ST_WALK: begin
				if (walk_end) begin
					state_d = bsf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsf_pkg::ST_CLEAR;
			end
		endcase
		if (cfg_wr) begin
			state_d = bsf_pkg::ST_CLEAR;
		end
	end

	// state outputs
	always_comb begin
		mem_ctl = '0;
		finish  = 1'b0;
		raddr   = rd_addr_q;
		waddr   = addr_s1;
		wdata   = set_word;
		unique case (state_q)
			bsf_pkg::ST_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = clr_addr_q;
				wdata         = '0;
			end
			bsf_pkg::ST_IDLE: begin
			end
			bsf_pkg::ST_SPLIT: begin
				mem_ctl.rd_en = 1'b1;
				raddr         = div_word_ext[AW-1:0];
			end
			bsf_pkg::ST_MODIFY: begin
				mem_ctl.wr_en = (cmd_q == bsf_pkg::CMD_WRITE) && in_range;
				finish        = 1'b1;
			end
			bsf_pkg::ST_WALK: begin
				mem_ctl.rd_en = issue && !find_hit;
				mem_ctl.wr_en = (cmd_q == bsf_pkg::CMD_INVERT) && valid_s1;
				wdata         = rdata ^ mask;
				finish        = walk_end;
			end
			default: begin
			end
		endcase
	end

	// result of the finishing cycle
	always_comb begin
		count_next = count_q;
		res_old    = 1'b0;
		if (state_q == bsf_pkg::ST_MODIFY && in_range) begin
			res_old = cur_bit;
			if (cmd_q == bsf_pkg::CMD_WRITE) begin
				if (val_q && !cur_bit) begin
					count_next = count_q + SW'(1);
				end else if (!val_q && cur_bit) begin
					count_next = count_q - SW'(1);
				end
			end
		end
		if (state_q == bsf_pkg::ST_WALK && cmd_q == bsf_pkg::CMD_INVERT) begin
			count_next = size_q - count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bsf_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			size_q     <= '0;
			count_q    <= '0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= finish && !cfg_wr;
			valid_s1 <= (state_q == bsf_pkg::ST_WALK) && issue && !walk_end;
			if (cfg_wr) begin
				clr_addr_q <= '0;
				size_q     <= size_in_use > SIZE_CAP ? SIZE_CAP : size_in_use;
				count_q    <= '0;
			end else begin
				if (state_q == bsf_pkg::ST_CLEAR) begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
				if (finish) begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= bsf_pkg::cmd_t'(command);
			idx_q     <= bit_index;
			val_q     <= bit_value;
			rd_addr_q <= '0;
			base_q    <= '0;
		end
		if (state_q == bsf_pkg::ST_SPLIT) begin
			addr_s1 <= div_word_ext[AW-1:0];
			off_s1  <= div_off;
		end
		if (state_q == bsf_pkg::ST_WALK && issue) begin
			rd_addr_q <= rd_addr_q + AW'(1);
			base_q    <= base_q + WORD_STEP;
			addr_s1   <= rd_addr_q;
			base_s1   <= base_q;
		end
		if (finish) begin
			old_bit_q   <= res_old;
			set_count_q <= count_next;
			any_set_q   <= count_next != '0;
			all_set_q   <= count_next == size_q;
			found_q     <= find_hit;
			found_pos_q <= find_hit ? find_pos[IW-1:0] : '0;
		end
	end

	assign done           = done_q;
	assign old_bit        = old_bit_q;
	assign set_count      = set_count_q;
	assign any_set        = any_set_q;
	assign all_set        = all_set_q;
	assign found_position = found_pos_q;
	assign found          = found_q;

endmodule

>>> design/bsf_checker.sv
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks of the bitmap block, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [bsf_pkg::SIZE_W-1:0] set_count,
	input logic                       any_set,
	input logic [bsf_pkg::IDX_W-1:0]  found_position,
	input logic                       found
);

	// a result is reported only as the block goes idle after working on a command
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done outside the end of a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> any_set == (set_count != '0))
		else $error("any_set disagrees with set_count");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> found_position == '0)
		else $error("failed search reports a position");

endmodule

bind bitmap_set_test_find_first bsf_checker u_bsf_checker (.*);
